[hw/rtl/bpt_pkg.sv]
// bpt_pkg: shared widths, register codes and curve-degree codes for the
// bezier point and tangent evaluator; no dependencies
`default_nettype none

package bpt_pkg;

    // coordinate and parameter formats
    localparam int COORD_BITS      = 16;
    localparam int PARAM_FRAC_BITS = 16;

    // derived field widths
    localparam int PARAM_W = PARAM_FRAC_BITS + 1;      // t, with 1.0 representable
    localparam int POS_W   = COORD_BITS;               // rounded curve point
    localparam int SLOPE_W = COORD_BITS + 3;           // rounded tangent
    localparam int POINT_W = 3 * COORD_BITS;           // packed x, y, z
    localparam int CFG_W   = POINT_W;                  // widest register
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINT_ZERO   = 3'd0,
        CFG_POINT_ONE    = 3'd1,
        CFG_POINT_TWO    = 3'd2,
        CFG_POINT_THREE  = 3'd3,
        CFG_CURVE_DEGREE = 3'd4
    } t_cfg_idx;

    // curve degree codes
    typedef enum logic {
        DEG_QUAD  = 1'b0,
        DEG_CUBIC = 1'b1
    } t_degree;

endpackage

`default_nettype wire

[hw/rtl/bpt_in_if.sv]
// bpt_in_if: request channel carrying the curve parameter t
// depends on bpt_pkg for the field width
`default_nettype none

interface bpt_in_if;
    logic                         valid;
    logic                         ready;
    logic [bpt_pkg::PARAM_W-1:0]  curve_param;

    modport source (output valid, output curve_param, input ready);
    modport sink   (input valid, input curve_param, output ready);
endinterface

`default_nettype wire

[hw/rtl/bpt_out_if.sv]
// bpt_out_if: result channel carrying the rounded point and tangent
// depends on bpt_pkg for the field widths
`default_nettype none

interface bpt_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bpt_pkg::POS_W-1:0]    pos_x;
    logic signed [bpt_pkg::POS_W-1:0]    pos_y;
    logic signed [bpt_pkg::POS_W-1:0]    pos_z;
    logic signed [bpt_pkg::SLOPE_W-1:0]  slope_x;
    logic signed [bpt_pkg::SLOPE_W-1:0]  slope_y;
    logic signed [bpt_pkg::SLOPE_W-1:0]  slope_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output slope_x, output slope_y, output slope_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input slope_x, input slope_y, input slope_z, output ready);
endinterface

`default_nettype wire

[hw/rtl/bezier_point_and_tangent_eval_core.sv]
// Throughput: one request per cycle while the output is not stalled; seven
// register stages, each with its own valid bit, and a stage takes new data
// whenever it is empty or moves on, so a stalled output holds only the stages
// behind it.
// Reset (synchronous, active low): all stages empty, control points zero,
// curve degree cubic.
// bezier point and tangent evaluator, top level; depends on bpt_pkg,
// bpt_in_if and bpt_out_if
`default_nettype none

module bezier_point_and_tangent_eval_core (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [bpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [bpt_pkg::CFG_W-1:0]      i_cfg_data,
    bpt_in_if.sink                        i_in,
    bpt_out_if.source                     o_out
);
    import bpt_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int F  = PARAM_FRAC_BITS;
    localparam int NS = 7;                       // pipeline stages

    localparam int SQ_W = 2 * F + 1;             // r*r, r*t, t*t
    localparam int CU_W = 3 * F + 1;             // cubic monomials
    localparam int PW_W = 3 * F + 3;             // point weights
    localparam int SW_W = 2 * F + 2;             // difference weights
    localparam int D_W  = C + 1;                 // point differences
    localparam int PP_W = PW_W + 1 + C;          // weighted point product
    localparam int SP_W = SW_W + 1 + D_W;        // weighted difference product
    localparam int PS_W = PP_W + 2;              // point sum
    localparam int SS_W = SP_W + 2;              // tangent sum

    localparam logic [PARAM_W-1:0] ONE_T    = PARAM_W'(1) << F;
    localparam logic [PS_W-1:0]    POS_HALF = PS_W'(1) << (3 * F - 1);
    localparam logic [SS_W-1:0]    SLP_HALF = SS_W'(1) << (2 * F - 1);

    // configuration registers
    logic [POINT_W-1:0] r_pt [4];
    t_degree            r_degree;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_pt[k] <= '0;
            end
            r_degree <= DEG_CUBIC;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_POINT_ZERO:   r_pt[0] <= i_cfg_data[POINT_W-1:0];
                CFG_POINT_ONE:    r_pt[1] <= i_cfg_data[POINT_W-1:0];
                CFG_POINT_TWO:    r_pt[2] <= i_cfg_data[POINT_W-1:0];
                CFG_POINT_THREE:  r_pt[3] <= i_cfg_data[POINT_W-1:0];
                CFG_CURVE_DEGREE: r_degree <= t_degree'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    // stage advance chain: a stage loads when empty or when its successor loads
    logic [NS:1]   adv;
    logic [NS-1:0] vld_in;
    logic [NS:1]   r_vld;

    always_comb begin
        adv[NS] = !r_vld[NS] || o_out.ready;
        for (int i = NS - 1; i >= 1; i--) begin
            adv[i] = !r_vld[i] || adv[i+1];
        end
        vld_in[0] = i_in.valid;
        for (int i = 1; i < NS; i++) begin
            vld_in[i] = r_vld[i];
        end
    end

    assign i_in.ready = adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 1; i <= NS; i++) begin
                if (adv[i]) begin
                    r_vld[i] <= vld_in[i-1];
                end
            end
        end
    end

    // stage 1: saturate t, form r = 1 - t
    logic [PARAM_W-1:0] r_t1, r_r1;
    logic [PARAM_W-1:0] t_sat;

    assign t_sat = (i_in.curve_param > ONE_T) ? ONE_T : i_in.curve_param;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_t1 <= t_sat;
            r_r1 <= ONE_T - t_sat;
        end
    end

    // stage 2: second-order monomials
    logic [PARAM_W-1:0] r_t2, r_r2;
    logic [SQ_W-1:0]    r_rr2, r_rt2, r_tt2;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_t2  <= r_t1;
            r_r2  <= r_r1;
            r_rr2 <= SQ_W'(r_r1) * SQ_W'(r_r1);
            r_rt2 <= SQ_W'(r_r1) * SQ_W'(r_t1);
            r_tt2 <= SQ_W'(r_t1) * SQ_W'(r_t1);
        end
    end

    // stage 3: third-order monomials
    logic [PARAM_W-1:0] r_t3, r_r3;
    logic [SQ_W-1:0]    r_rr3, r_rt3, r_tt3;
    logic [CU_W-1:0]    r_rrr3, r_rrt3, r_rtt3, r_ttt3;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_t3   <= r_t2;
            r_r3   <= r_r2;
            r_rr3  <= r_rr2;
            r_rt3  <= r_rt2;
            r_tt3  <= r_tt2;
            r_rrr3 <= CU_W'(r_rr2) * CU_W'(r_r2);
            r_rrt3 <= CU_W'(r_rr2) * CU_W'(r_t2);
            r_rtt3 <= CU_W'(r_rt2) * CU_W'(r_t2);
            r_ttt3 <= CU_W'(r_tt2) * CU_W'(r_t2);
        end
    end

    // stage 4: basis weights, all scaled to a common 2^-3F (point)
    // and 2^-2F (tangent)
    logic [PW_W-1:0] r_pw [4];
    logic [SW_W-1:0] r_sw [3];
    logic [PW_W-1:0] n_pw [4];
    logic [SW_W-1:0] n_sw [3];

    always_comb begin
        if (r_degree == DEG_CUBIC) begin
            n_pw[0] = PW_W'(r_rrr3);
            n_pw[1] = (PW_W'(r_rrt3) << 1) + PW_W'(r_rrt3);
            n_pw[2] = (PW_W'(r_rtt3) << 1) + PW_W'(r_rtt3);
            n_pw[3] = PW_W'(r_ttt3);
            n_sw[0] = (SW_W'(r_rr3) << 1) + SW_W'(r_rr3);
            n_sw[1] = (SW_W'(r_rt3) << 2) + (SW_W'(r_rt3) << 1);
            n_sw[2] = (SW_W'(r_tt3) << 1) + SW_W'(r_tt3);
        end else begin
            n_pw[0] = PW_W'(r_rr3) << F;
            n_pw[1] = PW_W'(r_rt3) << (F + 1);
            n_pw[2] = PW_W'(r_tt3) << F;
            n_pw[3] = '0;
            n_sw[0] = SW_W'(r_r3) << (F + 1);
            n_sw[1] = SW_W'(r_t3) << (F + 1);
            n_sw[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_pw <= n_pw;
            r_sw <= n_sw;
        end
    end

    // coordinates and their forward differences, per axis
    logic signed [C-1:0]   crd [3][4];
    logic signed [D_W-1:0] dif [3][3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 4; k++) begin
                crd[a][k] = $signed(r_pt[k][a*C +: C]);
            end
            for (int k = 0; k < 3; k++) begin
                dif[a][k] = D_W'(crd[a][k+1]) - D_W'(crd[a][k]);
            end
        end
    end

    // stage 5: weighted products
    logic signed [PP_W-1:0] r_pp [3][4];
    logic signed [SP_W-1:0] r_sp [3][3];

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 4; k++) begin
                    r_pp[a][k] <= $signed({{(PP_W-PW_W){1'b0}}, r_pw[k]})
                                  * PP_W'(crd[a][k]);
                end
                for (int k = 0; k < 3; k++) begin
                    r_sp[a][k] <= $signed({{(SP_W-SW_W){1'b0}}, r_sw[k]})
                                  * SP_W'(dif[a][k]);
                end
            end
        end
    end

    // stage 6: partial sums, rounding half folded in
    logic signed [PS_W-1:0] r_pa [3], r_pb [3];
    logic signed [SS_W-1:0] r_sa [3], r_sb [3];

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            for (int a = 0; a < 3; a++) begin
                r_pa[a] <= PS_W'(r_pp[a][0]) + PS_W'(r_pp[a][1]);
                r_pb[a] <= PS_W'(r_pp[a][2]) + PS_W'(r_pp[a][3]) + $signed(POS_HALF);
                r_sa[a] <= SS_W'(r_sp[a][0]) + SS_W'(r_sp[a][1]);
                r_sb[a] <= SS_W'(r_sp[a][2]) + $signed(SLP_HALF);
            end
        end
    end

    // stage 7: final sum, floor shift gives round-half-up
    logic signed [PS_W-1:0]    psum [3];
    logic signed [SS_W-1:0]    ssum [3];
    logic signed [POS_W-1:0]   r_pos [3];
    logic signed [SLOPE_W-1:0] r_slp [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            psum[a] = r_pa[a] + r_pb[a];
            ssum[a] = r_sa[a] + r_sb[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            for (int a = 0; a < 3; a++) begin
                r_pos[a] <= $signed(psum[a][3*F +: POS_W]);
                r_slp[a] <= $signed(ssum[a][2*F +: SLOPE_W]);
            end
        end
    end

    // result channel
    assign o_out.valid   = r_vld[NS];
    assign o_out.pos_x   = r_pos[0];
    assign o_out.pos_y   = r_pos[1];
    assign o_out.pos_z   = r_pos[2];
    assign o_out.slope_x = r_slp[0];
    assign o_out.slope_y = r_slp[1];
    assign o_out.slope_z = r_slp[2];

endmodule

`default_nettype wire
